/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_sig, rst_sig, expr, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_IMPLY_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tpsd_pkg.sv */
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsd_pkg;

  localparam int DIM_W   = 13;  // width of size registers and counters
  localparam int COORD_W = 12;  // width of output coordinates
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RLE_ENABLE   = 3'd0,
    REG_PIXEL_FORMAT = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_TOP_DOWN     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_GRAY8  = 2'd0,
    FMT_BGR24  = 2'd1,
    FMT_BGRA32 = 2'd2
  } pixel_fmt_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        color;
    logic [7:0]         repeat_count;
    logic               last_of_image;
  } result_t;

endpackage

`default_nettype wire

/* src/tga_pixel_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// Decodes raw or run-length TGA pixel bytes into ARGB pixel writes.
// ----------------------------------------------------------------------------
//
//   channel   signals                               direction
//   -------   -----------------------------------   ---------
//   input     in_valid/in_ready, data_byte,         in
//             start_image
//   output    out_valid/out_ready, pixel_x,         out
//             pixel_y, color, repeat_count,
//             last_of_image
//   config    cfg_we, cfg_index, cfg_data           in
//
// One byte is taken per clock while in_ready is high. Each byte is decoded in
// the cycle it transfers, against the packet, pixel and row counters, and a
// pixel write (if any) lands in the output or skid register on that same edge.
// A two-entry output stage (output register plus skid register) keeps
// in_ready registered: it drops only while the skid register holds a write.
// Reset is synchronous; it restores the register defaults and clears all
// decoding state. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_pixel_stream_decoder_core (
  input  wire                              clk,
  input  wire                              rst,
  // configuration
  input  wire                              cfg_we,
  input  wire [tpsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tpsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // byte input
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [7:0]                        data_byte,
  input  wire                              start_image,
  // pixel write output
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tpsd_pkg::COORD_W-1:0]     pixel_x,
  output logic [tpsd_pkg::COORD_W-1:0]     pixel_y,
  output logic [31:0]                      color,
  output logic [7:0]                       repeat_count,
  output logic                             last_of_image
);

  localparam int DW = tpsd_pkg::DIM_W;

  // configuration registers
  logic          rle_enable;
  logic [1:0]    pixel_format;
  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic          top_down;

  // decoding state
  logic [7:0]    packet_left,   packet_left_next;
  logic          packet_is_run, packet_is_run_next;
  logic [1:0]    byte_in_pixel, byte_in_pixel_next;
  logic [23:0]   partial_pixel, partial_pixel_next;
  logic [DW-1:0] column,        column_next;
  logic [DW-1:0] rows_done,     rows_done_next;
  logic          image_done,    image_done_next;

  // output stage
  tpsd_pkg::result_t out_data, skid_data, res;
  logic              skid_valid;
  logic              has_result;
  logic              in_xfer;

  // state seen by this byte, after an optional restart
  logic [7:0]    cur_left;
  logic          cur_run;
  logic [1:0]    cur_bip;
  logic [23:0]   cur_partial;
  logic [DW-1:0] cur_column;
  logic [DW-1:0] cur_rows;
  logic          cur_done;

  logic [DW-1:0] eff_w, eff_h;
  logic [2:0]    pix_size;
  logic [31:0]   pix_color;
  logic [DW-1:0] remaining;
  logic [7:0]    count;
  logic [DW-1:0] row;
  logic          last_row;
  logic          row_end;
  logic [DW-1:0] row_flip;

  assign in_xfer  = in_valid && in_ready;
  assign in_ready = !skid_valid;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_enable   <= 1'b0;
      pixel_format <= tpsd_pkg::FMT_BGRA32;
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
      top_down     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpsd_pkg::REG_RLE_ENABLE:   rle_enable   <= cfg_data[0];
        tpsd_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        tpsd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DW-1:0];
        tpsd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DW-1:0];
        tpsd_pkg::REG_TOP_DOWN:     top_down     <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective image size: zero counts as one, saturate at the maximum
  // --------------------------------------------------------------------------
  always_comb begin
    if (image_width == '0)
      eff_w = DW'(1);
    else if (image_width > tpsd_pkg::MAX_WIDTH)
      eff_w = tpsd_pkg::MAX_WIDTH;
    else
      eff_w = image_width;

    if (image_height == '0)
      eff_h = DW'(1);
    else if (image_height > tpsd_pkg::MAX_HEIGHT)
      eff_h = tpsd_pkg::MAX_HEIGHT;
    else
      eff_h = image_height;
  end

  // --------------------------------------------------------------------------
  // Byte decode
  // --------------------------------------------------------------------------
  always_comb begin
    // start_image wipes the state before this byte is looked at
    if (start_image) begin
      cur_left    = '0;
      cur_run     = 1'b0;
      cur_bip     = '0;
      cur_partial = '0;
      cur_column  = '0;
      cur_rows    = '0;
      cur_done    = 1'b0;
    end else begin
      cur_left    = packet_left;
      cur_run     = packet_is_run;
      cur_bip     = byte_in_pixel;
      cur_partial = partial_pixel;
      cur_column  = column;
      cur_rows    = rows_done;
      cur_done    = image_done;
    end

    case (pixel_format)
      tpsd_pkg::FMT_GRAY8: pix_size = 3'd1;
      tpsd_pkg::FMT_BGR24: pix_size = 3'd3;
      default:             pix_size = 3'd4;  // BGRA32, and code 3 alike
    endcase

    case (pixel_format)
      tpsd_pkg::FMT_GRAY8: pix_color = {8'hFF, data_byte, data_byte, data_byte};
      tpsd_pkg::FMT_BGR24: pix_color = {8'hFF, data_byte, cur_partial[15:0]};
      default:             pix_color = {data_byte, cur_partial};
    endcase

    // pixels left in the row; a column past a lowered width writes one pixel
    remaining = (cur_column < eff_w) ? (eff_w - cur_column) : DW'(1);

    // a run is clipped at the row end
    if (rle_enable && cur_run) begin
      if (DW'(cur_left) < remaining)
        count = cur_left;
      else
        count = remaining[7:0];
    end else begin
      count = 8'd1;
    end

    row      = (cur_rows < eff_h) ? cur_rows : (eff_h - DW'(1));
    last_row = ({1'b0, cur_rows} + (DW+1)'(1)) >= {1'b0, eff_h};
    row_end  = DW'(count) >= remaining;
    row_flip = eff_h - DW'(1) - row;

    res.pixel_x       = cur_column[tpsd_pkg::COORD_W-1:0];
    res.pixel_y       = top_down ? row[tpsd_pkg::COORD_W-1:0]
                                 : row_flip[tpsd_pkg::COORD_W-1:0];
    res.color         = pix_color;
    res.repeat_count  = count;
    res.last_of_image = row_end && last_row;

    // default: hold the (possibly restarted) state
    packet_left_next   = cur_left;
    packet_is_run_next = cur_run;
    byte_in_pixel_next = cur_bip;
    partial_pixel_next = cur_partial;
    column_next        = cur_column;
    rows_done_next     = cur_rows;
    image_done_next    = cur_done;
    has_result         = 1'b0;

    if (cur_done) begin
      // image complete: ignore bytes until a restart
    end else if (rle_enable && (cur_left == 8'd0)) begin
      // packet header
      packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
      packet_is_run_next = data_byte[7];
      byte_in_pixel_next = '0;
      partial_pixel_next = '0;
    end else if (({1'b0, cur_bip} + 3'd1) < pix_size) begin
      // collect one more byte of the pixel
      case (cur_bip)
        2'd0:    partial_pixel_next = {cur_partial[23:8], data_byte};
        2'd1:    partial_pixel_next = {cur_partial[23:16], data_byte, cur_partial[7:0]};
        default: partial_pixel_next = {data_byte, cur_partial[15:0]};
      endcase
      byte_in_pixel_next = cur_bip + 2'd1;
    end else begin
      // pixel complete: emit a write and advance
      has_result         = 1'b1;
      byte_in_pixel_next = '0;
      partial_pixel_next = '0;

      if (rle_enable) begin
        packet_left_next = cur_run ? 8'd0 : (cur_left - 8'd1);
      end

      if (row_end) begin
        column_next      = '0;
        packet_left_next = 8'd0;  // a packet never crosses the row end
        if (last_row)
          image_done_next = 1'b1;
        else
          rows_done_next  = cur_rows + DW'(1);
      end else begin
        column_next = cur_column + DW'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left   <= '0;
      packet_is_run <= 1'b0;
      byte_in_pixel <= '0;
      partial_pixel <= '0;
      column        <= '0;
      rows_done     <= '0;
      image_done    <= 1'b0;
    end else if (in_xfer) begin
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_in_pixel <= byte_in_pixel_next;
      partial_pixel <= partial_pixel_next;
      column        <= column_next;
      rows_done     <= rows_done_next;
      image_done    <= image_done_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output slot frees up: refill from skid first, else from decode
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_xfer && has_result;
      end
    end else if (in_xfer && has_result) begin
      // output stalled: park the new write in the skid register
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (!skid_valid) begin
      skid_data <= res;
    end
  end

  assign pixel_x       = out_data.pixel_x;
  assign pixel_y       = out_data.pixel_y;
  assign color         = out_data.color;
  assign repeat_count  = out_data.repeat_count;
  assign last_of_image = out_data.last_of_image;

endmodule

`default_nettype wire

/* src/tpsd_checker.sv */
// ----------------------------------------------------------------------------
// tpsd_checker
// Port-level assertions for the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpsd_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [11:0] pixel_x,
  input wire [11:0] pixel_y,
  input wire [31:0] color,
  input wire [7:0]  repeat_count,
  input wire        last_of_image
);

  // a stalled write holds
  `ASSERT_IMPLY_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(color) && $stable(pixel_x) && $stable(pixel_y)
    && $stable(repeat_count) && $stable(last_of_image), "stalled write changed")

  // a write covers between one and 128 pixels
  `ASSERT_IMPLY(a_count_range, clk, rst, out_valid,
    (repeat_count != 8'd0) && (repeat_count <= 8'd128), "repeat count out of range")

  // a write never runs past the widest row
  `ASSERT_IMPLY(a_row_bound, clk, rst, out_valid,
    ({1'b0, pixel_x} + {5'd0, repeat_count}) <= 13'd4096, "write overruns row")

  // the input side is open right after reset
  `ASSERT_IMPLY(a_ready_after_rst, clk, 1'b0, $past(rst) && !rst, in_ready,
    "not ready after reset")

endmodule

bind tga_pixel_stream_decoder_core tpsd_checker u_tpsd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel_x       (pixel_x),
  .pixel_y       (pixel_y),
  .color         (color),
  .repeat_count  (repeat_count),
  .last_of_image (last_of_image)
);

`default_nettype wire

/* tb/sv/tb_tga_pixel_stream_decoder_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_pixel_stream_decoder_core
// Self-checking bench for the TGA pixel stream decoder. A directed section
// covers every format and mode, row clipping and the finished-image state.
// Randomized phases follow: well-formed raw and run-length images with random
// content, mixed with noise bytes and with register changes in mid-image.
// A local decoder model predicts each pixel write at the input transfer, and
// the output monitor checks every write against it, field by field.
// ----------------------------------------------------------------------------

module tb_tga_pixel_stream_decoder_core;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_LIMIT   = 5000;  // cycles without any transfer
  localparam int DRAIN_CYCLES  = 4;     // margin after the last write
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 100;
  localparam int CALM_PHASE    = 2;     // no idling on either side
  localparam int HOLD_PHASE    = 4;     // receiver holds off here
  // Format code 3 has no package name; the block treats it as BGRA32.
  localparam logic [1:0] FMT_BGRA32_ALT = 2'd3;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } stream_byte_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we    = 1'b0;
  logic [tpsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tpsd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic       in_valid    = 1'b0;
  wire        in_ready;
  logic [7:0] data_byte   = 8'h00;
  logic       start_image = 1'b0;

  wire                         out_valid;
  logic                        out_ready = 1'b0;
  wire [tpsd_pkg::COORD_W-1:0] pixel_x;
  wire [tpsd_pkg::COORD_W-1:0] pixel_y;
  wire [31:0]                  color;
  wire [7:0]                   repeat_count;
  wire                         last_of_image;

  always #HALF_PERIOD clk = ~clk;

  tga_pixel_stream_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_image  (start_image),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color        (color),
    .repeat_count (repeat_count),
    .last_of_image(last_of_image)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stream_byte_t      stream_bytes[$];   // bytes waiting to be offered
  stream_byte_t      offered;           // byte currently on the input port
  tpsd_pkg::result_t pending_writes[$]; // predicted pixel writes, oldest first

  int mismatches   = 0;
  int quiet_cycles = 0;
  int in_idle_pct  = 33;
  int out_idle_pct = 33;
  int phase_budget = 0;
  bit hold_arm     = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;

  // Register copies, at their reset values.
  logic        rle_on     = 1'b0;
  logic [1:0]  fmt_sel    = tpsd_pkg::FMT_BGRA32;
  logic [12:0] width_reg  = 13'd4096;
  logic [12:0] height_reg = 13'd4096;
  logic        top_first  = 1'b0;

  // Decoder model state.
  int          pkt_left  = 0;
  bit          pkt_run   = 1'b0;
  int          pix_bytes = 0;
  logic [23:0] pix_acc   = '0;
  int          col_pos   = 0;
  int          row_cnt   = 0;
  bit          img_done  = 1'b0;

  // Zero counts as one; anything above the maximum saturates.
  function automatic int limit_dim(logic [12:0] v, logic [12:0] cap);
    if (v == 0) return 1;
    return (v > cap) ? int'(cap) : int'(v);
  endfunction

  function automatic int bytes_per_pixel(logic [1:0] fmt);
    if (fmt == tpsd_pkg::FMT_GRAY8) return 1;
    if (fmt == tpsd_pkg::FMT_BGR24) return 3;
    return 4;
  endfunction

  // --------------------------------------------------------------------------
  // Decoder model: advance on one accepted byte, queue the write it causes.
  // --------------------------------------------------------------------------
  task automatic decode_byte(stream_byte_t it);
    int                w, h, size, left_in_row, count, row;
    bit                last_row, row_end;
    logic [31:0]       argb;
    tpsd_pkg::result_t wr;
    w = limit_dim(width_reg, tpsd_pkg::MAX_WIDTH);
    h = limit_dim(height_reg, tpsd_pkg::MAX_HEIGHT);
    if (it.start) begin
      pkt_left  = 0;
      pkt_run   = 1'b0;
      pix_bytes = 0;
      pix_acc   = '0;
      col_pos   = 0;
      row_cnt   = 0;
      img_done  = 1'b0;
    end
    // A finished image swallows bytes until the next start.
    if (img_done) return;

    // Out of packet in run-length mode: this byte is a packet header.
    if (rle_on && pkt_left == 0) begin
      pkt_left  = int'(it.data[6:0]) + 1;
      pkt_run   = it.data[7];
      pix_bytes = 0;
      pix_acc   = '0;
      return;
    end

    // Collect bytes until the pixel is complete; a format change in
    // mid-pixel completes it on the first byte at or past the new size.
    size = bytes_per_pixel(fmt_sel);
    if (pix_bytes + 1 < size) begin
      pix_acc = pix_acc | (24'(it.data) << (8 * pix_bytes));
      pix_bytes++;
      return;
    end

    case (fmt_sel)
      tpsd_pkg::FMT_GRAY8: argb = {8'hFF, it.data, it.data, it.data};
      tpsd_pkg::FMT_BGR24: argb = {8'hFF, it.data, pix_acc[15:0]};
      default:             argb = {it.data, pix_acc};
    endcase
    pix_bytes = 0;
    pix_acc   = '0;

    // Clip runs at the row end; a column past a lowered width writes one
    // pixel and closes the row. A row past a lowered height is the last one.
    left_in_row = (col_pos < w) ? w - col_pos : 1;
    count = 1;
    if (rle_on && pkt_run) count = (pkt_left < left_in_row) ? pkt_left : left_in_row;
    row      = (row_cnt < h) ? row_cnt : h - 1;
    last_row = (row_cnt + 1 >= h);
    row_end  = (count >= left_in_row);

    wr.pixel_x       = col_pos[11:0];
    wr.pixel_y       = top_first ? row[11:0] : 12'(h - 1 - row);
    wr.color         = argb;
    wr.repeat_count  = count[7:0];
    wr.last_of_image = row_end && last_row;
    pending_writes.push_back(wr);

    // Raw mode leaves any packet state untouched.
    if (rle_on) pkt_left = pkt_run ? 0 : ((pkt_left - 1) & 8'hFF);

    if (row_end) begin
      col_pos  = 0;
      pkt_left = 0;
      if (last_row) img_done = 1'b1;
      else row_cnt = (row_cnt + 1) & 13'h1FFF;
    end else begin
      col_pos = (col_pos + count) & 13'h1FFF;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer queued bytes, predict at each transfer, idle at
  // random. Hold valid and payload steady until the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed_bytes
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(offered);
      if (!in_valid || in_ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          offered = stream_bytes.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= offered.data;
          start_image <= offered.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check every write transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : take_writes
    tpsd_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected write x=%0d y=%0d color=0x%0h: expected none, actual one",
                   $time, pixel_x, pixel_y, color);
        end else begin
          want = pending_writes.pop_front();
          compare_field("pixel_x", 32'(want.pixel_x), 32'(pixel_x));
          compare_field("pixel_y", 32'(want.pixel_y), 32'(pixel_y));
          compare_field("color", want.color, color);
          compare_field("repeat_count", 32'(want.repeat_count), 32'(repeat_count));
          compare_field("last_of_image", 32'(want.last_of_image), 32'(last_of_image));
        end
      end
      // Once armed, drop ready for a long stretch so the output stage fills
      // and the input backs up; otherwise stall at random.
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        out_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing transfers for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_tga_pixel_stream_decoder_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] data, logic start);
    stream_byte_t it;
    it.data  = data;
    it.start = start;
    stream_bytes.push_back(it);
    phase_budget--;
  endtask

  // Write all five registers on consecutive edges; only call while idle.
  task automatic apply_config(logic rle, logic [1:0] fmt, logic [12:0] w, logic [12:0] h,
                              logic td);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tpsd_pkg::REG_RLE_ENABLE;
    cfg_data  <= 13'(rle);
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_PIXEL_FORMAT;
    cfg_data  <= 13'(fmt);
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= tpsd_pkg::REG_TOP_DOWN;
    cfg_data  <= 13'(td);
    @(posedge clk);
    cfg_we <= 1'b0;
    rle_on     = rle;
    fmt_sel    = fmt;
    width_reg  = w;
    height_reg = h;
    top_first  = td;
  endtask

  // Wait until every byte has transferred and every write has come back,
  // then give the block its latency before touching the registers.
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || in_valid || pending_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly small sizes so images complete; now and then an extreme.
  function automatic logic [12:0] pick_dim(int small_max);
    if ($urandom_range(9) < 7) return 13'($urandom_range(small_max, 1));
    case ($urandom_range(4))
      0:       return 13'd0;
      1:       return 13'd4096;
      2:       return 13'd8191;
      3:       return 13'd4097;
      default: return 13'($urandom_range(40, 9));
    endcase
  endfunction

  // Queue one image under the current registers, stopping at the budget.
  // Packets mostly fit the row; a few literals overrun it on purpose.
  task automatic emit_image(bit with_start);
    int w, h, size, row, col, k, left, npix;
    bit first, run_pkt;
    w     = limit_dim(width_reg, tpsd_pkg::MAX_WIDTH);
    h     = limit_dim(height_reg, tpsd_pkg::MAX_HEIGHT);
    size  = bytes_per_pixel(fmt_sel);
    first = with_start;
    for (row = 0; row < h && phase_budget > 0; row++) begin
      col = 0;
      while (col < w && phase_budget > 0) begin
        if (rle_on) begin
          left = w - col;
          k = ($urandom_range(7) == 0) ? $urandom_range(128, 1)
                                       : $urandom_range((left < 8) ? left : 8, 1);
          run_pkt = 1'($urandom_range(1));
          queue_byte({run_pkt, 7'(k - 1)}, first);
          first = 1'b0;
          npix = run_pkt ? 1 : ((k > left && $urandom_range(3) != 0) ? left : k);
          repeat (npix * size) queue_byte(8'($urandom_range(255)), 1'b0);
          col += run_pkt ? k : npix;
        end else begin
          repeat (size) begin
            queue_byte(8'($urandom_range(255)), first);
            first = 1'b0;
          end
          col++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    int  p;
    bit  resume;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Raw gray, 3x2 bottom-up: byte extremes, image end, then a byte that
    // the finished image must ignore.
    apply_config(1'b0, tpsd_pkg::FMT_GRAY8, 13'd3, 13'd2, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    wait_drained();

    // Run-length BGR24, width 4, height zero (one row), top-down: a literal
    // of two, then a run of 128 clipped to the two pixels left in the row.
    apply_config(1'b1, tpsd_pkg::FMT_BGR24, 13'd4, 13'd0, 1'b1);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h30, 1'b0);
    queue_byte(8'h40, 1'b0);
    queue_byte(8'h50, 1'b0);
    queue_byte(8'h60, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC0, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'h3F, 1'b0);
    wait_drained();

    // Format code 3, width zero, height saturated: one pixel, then leave a
    // pixel two bytes in.
    apply_config(1'b0, FMT_BGRA32_ALT, 13'd0, 13'd8191, 1'b0);
    queue_byte(8'h11, 1'b1);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h44, 1'b0);
    queue_byte(8'hE7, 1'b0);
    queue_byte(8'h18, 1'b0);
    wait_drained();

    // Switch to gray in mid-pixel and lower the height below the rows done.
    apply_config(1'b0, tpsd_pkg::FMT_GRAY8, 13'd2, 13'd1, 1'b1);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'hC3, 1'b0);
    wait_drained();

    // Random phases. Each starts from idle; some resume the image left by
    // the previous phase under new registers instead of starting a new one.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      in_idle_pct  = (p == CALM_PHASE) ? 0 : 33;
      out_idle_pct = (p == CALM_PHASE) ? 0 : 33;
      if (p == HOLD_PHASE) begin
        // Every byte makes a write here, so the hold-off backs up the input.
        apply_config(1'b0, tpsd_pkg::FMT_GRAY8, 13'd8, 13'd6, 1'($urandom_range(1)));
        @(negedge clk);
        hold_arm = 1'b1;
        resume   = 1'b0;
      end else begin
        apply_config(1'($urandom_range(1)), 2'($urandom_range(3)), pick_dim(8), pick_dim(6),
                     1'($urandom_range(1)));
        resume = ($urandom_range(3) == 0);
      end
      phase_budget = PHASE_ITEMS;
      while (phase_budget > 0) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(6, 1))
            queue_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        end else begin
          emit_image(!resume);
          resume = 1'b0;
        end
      end
      wait_drained();
    end

    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("tb_tga_pixel_stream_decoder_core: PASS");
    end else begin
      $display("tb_tga_pixel_stream_decoder_core: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/tpsd_pkg.sv
src/tga_pixel_stream_decoder_core.sv
src/tpsd_checker.sv
tb/sv/tb_tga_pixel_stream_decoder_core.sv
